// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assert failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/rwmcd_pkg.sv =====
// Package: constants and types of the read/write mask conflict dispatcher.
`default_nettype none
package rwmcd_pkg;
  localparam int MaxTasks     = 16;
  localparam int SlotW        = 4;
  localparam int ResBits      = 64;
  localparam int ChunkShift   = 9;
  localparam int EntW         = 20;
  localparam int JobW         = 12;
  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_START    = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd0;
  localparam logic [1:0] PH_PENDING = 2'd1;
  localparam logic [1:0] PH_RUNNING = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [63:0] reads;
    logic [63:0] writes;
    logic        bound_to_entities;
    logic [19:0] entity_total;
    logic        pinned_main;
    logic [4:0]  task_total;
  } in_item_t;

  typedef struct packed {
    logic        is_launch;
    logic [3:0]  launched_slot;
    logic [11:0] job_total;
    logic        to_main_queue;
    logic        step_finished;
    logic        bad_completion;
    logic        last;
  } out_item_t;

  // Chunk count: ceil(e/512), saturated to 4095.
  function automatic logic [JobW-1:0] chunk_jobs(input logic [EntW-1:0] e);
    logic [EntW-ChunkShift:0] q;
    q = {1'b0, e[EntW-1:ChunkShift]} + {{(EntW-ChunkShift){1'b0}}, |e[ChunkShift-1:0]};
    chunk_jobs = (q > 12'd4095) ? 12'd4095 : q[JobW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rwmcd_if.sv =====
// Valid/ready channel interfaces for the dispatcher.
`default_nettype none
interface rwmcd_in_if import rwmcd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rwmcd_out_if import rwmcd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rw_mask_conflict_dispatcher.sv =====
// Top level: task table, busy masks and sequential dispatch scanner.
//  channel | dir | beat
//  in_ch   | in  | one event (load, start, completion)
//  out_ch  | out | launch record or closing status record
// Load is accepted, then the status beat is offered.
// Start and completion scan the step in order, with a launch beat per launched task,
// one entry per cycle through the shared mask compare unit while no beat is waiting.
// A completion that finishes a task first rebuilds the busy masks; a rejected one goes straight to status.
// Every launch or status beat holds the sequence until out_ch takes it.
// Synchronous reset marks all tasks done and clears busy masks.
`include "assert_macros.svh"
`default_nettype none
module rw_mask_conflict_dispatcher import rwmcd_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  rwmcd_in_if.sink  in_ch,
  rwmcd_out_if.source out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0, S_REBUILD = 3'd1, S_SCAN = 3'd2,
                         S_EMIT = 3'd3, S_STATUS = 3'd4;

  logic [ResBits-1:0] task_reads [MaxTasks];
  logic [ResBits-1:0] task_writes [MaxTasks];
  logic [EntW-1:0]    task_entities [MaxTasks];
  logic [1:0]         task_flags [MaxTasks];
  logic [1:0]         task_phase [MaxTasks];
  logic [JobW-1:0]    jobs_left [MaxTasks];
  logic [ResBits-1:0] busy_reads, busy_writes;
  logic [4:0]         step_size;
  logic [2:0]         state;
  logic [SlotW:0]     idx;
  out_item_t          obuf;

  logic [SlotW-1:0] ix;
  logic in_step, launchable, bound, step_clear, bad_cmp;
  logic [JobW-1:0] jobs;
  in_item_t d;

  assign ix = idx[SlotW-1:0];
  assign d = in_ch.data;
  assign in_step = ({1'b0, idx} < {1'b0, step_size}) && (idx < 5'(MaxTasks));
  assign bound = task_flags[ix][0];
  assign launchable = (task_phase[ix] == PH_PENDING) &&
      ((task_writes[ix] & (busy_reads | busy_writes)) == '0) &&
      ((task_reads[ix] & busy_writes) == '0);
  assign jobs = bound ? chunk_jobs(task_entities[ix]) : JobW'(1);

  // Reject a completion outside the step, not running, or with no jobs left.
  assign bad_cmp = (d.kind == KIND_COMPLETE) &&
      (({1'b0, d.slot} >= step_size) || (task_phase[d.slot] != PH_RUNNING) ||
       (jobs_left[d.slot] == '0));

  always_comb begin
    step_clear = 1'b1;
    for (int i = 0; i < MaxTasks; i++)
      if (i < int'(step_size) && task_phase[i] != PH_DONE) step_clear = 1'b0;
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_EMIT) || (state == S_STATUS);
  assign out_ch.data  = obuf;

  // Sequence: one table entry per cycle, held while out_ch has not taken a beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_size <= '0;
      busy_reads <= '0;
      busy_writes <= '0;
      idx <= '0;
      for (int i = 0; i < MaxTasks; i++) begin
        task_phase[i] <= PH_DONE;
        jobs_left[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          idx <= '0;
          case (d.kind)
            KIND_LOAD: begin
              task_reads[d.slot] <= d.reads;
              task_writes[d.slot] <= d.writes;
              task_entities[d.slot] <= d.entity_total;
              task_flags[d.slot] <= {d.pinned_main, d.bound_to_entities};
              state <= S_STATUS;
            end
            KIND_START: begin
              step_size <= (d.task_total > 5'(MaxTasks)) ? 5'(MaxTasks) : d.task_total;
              for (int i = 0; i < MaxTasks; i++)
                if (i < int'(d.task_total)) begin
                  task_phase[i] <= PH_PENDING;
                  jobs_left[i] <= '0;
                end
              busy_reads <= '0;
              busy_writes <= '0;
              state <= S_SCAN;
            end
            KIND_COMPLETE: begin
              if (bad_cmp) begin
                state <= S_STATUS;
              end else begin
                jobs_left[d.slot] <= jobs_left[d.slot] - 1'b1;
                if (jobs_left[d.slot] == JobW'(1)) begin
                  task_phase[d.slot] <= PH_DONE;
                  busy_reads <= '0;
                  busy_writes <= '0;
                  state <= S_REBUILD;
                end else state <= S_SCAN;
              end
            end
            default: state <= S_STATUS;
          endcase
        end
        // Rebuild busy masks from running tasks.
        S_REBUILD: begin
          if (!in_step) begin
            idx <= '0;
            state <= S_SCAN;
          end else begin
            if (task_phase[ix] == PH_RUNNING) begin
              busy_reads <= busy_reads | task_reads[ix];
              busy_writes <= busy_writes | task_writes[ix];
            end
            idx <= idx + 1'b1;
          end
        end
        // Scan pending tasks in order.
        S_SCAN: begin
          if (!in_step) state <= S_STATUS;
          else begin
            idx <= idx + 1'b1;
            if (launchable) begin
              if (bound && task_entities[ix] == '0) task_phase[ix] <= PH_DONE;
              else begin
                task_phase[ix] <= PH_RUNNING;
                jobs_left[ix] <= jobs;
                busy_reads <= busy_reads | task_reads[ix];
                busy_writes <= busy_writes | task_writes[ix];
                state <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: if (out_ch.ready) state <= S_SCAN;
        S_STATUS: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output record register: hold it while a beat is offered.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && in_step && launchable && !(bound && task_entities[ix] == '0)) begin
      obuf <= '{is_launch: 1'b1, launched_slot: ix, job_total: jobs,
                to_main_queue: !bound && task_flags[ix][1], step_finished: 1'b0,
                bad_completion: 1'b0, last: 1'b0};
    end else if (state != S_STATUS && state != S_EMIT) begin
      obuf <= '{is_launch: 1'b0, launched_slot: '0, job_total: '0, to_main_queue: 1'b0,
                step_finished: step_clear, bad_completion: (state == S_IDLE) && bad_cmp,
                last: 1'b1};
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst, in_ch.ready |-> !out_ch.valid)
  `ASSERT_CLK(a_launch_not_last, clk, rst, (state == S_EMIT) |-> (obuf.is_launch && !obuf.last))
  `ASSERT_CLK(a_status_last, clk, rst, (state == S_STATUS) |-> (obuf.last && !obuf.is_launch))
endmodule
`default_nettype wire
